// ===== hdl/hid_report_key_event_diff_assert.svh =====
// ----------------------------------------------------------------------------
// hid_report_key_event_diff_assert.svh
// Assertion macros used by the key event diff top module.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_KEY_EVENT_DIFF_ASSERT_SVH
`define HID_REPORT_KEY_EVENT_DIFF_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HKD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HKD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hkd_pkg.sv =====
// ----------------------------------------------------------------------------
// hkd_pkg
// Types and constants for the HID report key event diff block.
// ----------------------------------------------------------------------------
package hkd_pkg;

    localparam int CODE_W     = 8;
    localparam int KEY_CODES  = 256;
    localparam int IN_SLOTS   = 6;
    localparam int MOD_EVENTS = 6;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    // command on the input tuser
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // answer kind on the output tuser
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // modifier event order: LCtrl, RCtrl, LShift, RShift, LAlt, RAlt
    localparam logic [2:0] MOD_BIT [MOD_EVENTS] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};
    localparam logic [CODE_W-1:0] MOD_CODE [MOD_EVENTS] =
        '{8'hE0, 8'hE4, 8'hE1, 8'hE5, 8'hE2, 8'hE6};

    // what one slot lane found
    typedef struct packed {
        logic press;
        logic release_;
    } t_lane_res;

    // key-down map write port
    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] addr;
        logic              down;
    } t_map_wr;

endpackage

// ===== hdl/hkd_lane.sv =====
// ----------------------------------------------------------------------------
// hkd_lane
// One slot lane: finds whether its current code is new and whether its
// previous code has gone away.
// ----------------------------------------------------------------------------
module hkd_lane
    import hkd_pkg::*;
#(
    parameter int SLOTS = 6
) (
    input  logic [CODE_W-1:0]            i_cur_code,
    input  logic [CODE_W-1:0]            i_prev_code,
    input  logic [SLOTS-1:0][CODE_W-1:0] i_cur_all,
    input  logic [SLOTS-1:0][CODE_W-1:0] i_prev_all,
    output t_lane_res                    o_res
);

    logic in_prev;
    logic in_cur;

    // membership search over the other report
    always_comb begin
        in_prev = 1'b0;
        in_cur  = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (i_prev_all[j] == i_cur_code) begin
                in_prev = 1'b1;
            end
            if (i_cur_all[j] == i_prev_code) begin
                in_cur = 1'b1;
            end
        end
    end

    // empty slots never produce events
    assign o_res.press    = (i_cur_code != '0) && !in_prev;
    assign o_res.release_ = (i_prev_code != '0) && !in_cur;

endmodule

// ===== hdl/hkd_merge.sv =====
// ----------------------------------------------------------------------------
// hkd_merge
// Combines modifier changes and lane results into one ordered event mask:
// modifiers first, then presses in slot order, then releases.
// ----------------------------------------------------------------------------
module hkd_merge
    import hkd_pkg::*;
#(
    parameter int SLOTS = 6,
    localparam int NEV  = MOD_EVENTS + 2 * SLOTS
) (
    input  logic [7:0]            i_mods,
    input  logic [7:0]            i_prev_mods,
    input  t_lane_res [SLOTS-1:0] i_lane,
    output logic [NEV-1:0]        o_mask,
    output logic [MOD_EVENTS-1:0] o_mod_down,
    output logic                  o_any
);

    logic [7:0]            changed;
    logic [MOD_EVENTS-1:0] mod_chg;
    logic [SLOTS-1:0]      press;
    logic [SLOTS-1:0]      rel;

    assign changed = i_mods ^ i_prev_mods;

    // modifier bits in event order; GUI bits are never looked at
    always_comb begin
        for (int k = 0; k < MOD_EVENTS; k++) begin
            mod_chg[k]    = changed[MOD_BIT[k]];
            o_mod_down[k] = i_mods[MOD_BIT[k]];
        end
        for (int i = 0; i < SLOTS; i++) begin
            press[i] = i_lane[i].press;
            rel[i]   = i_lane[i].release_;
        end
    end

    assign o_mask = {rel, press, mod_chg};
    assign o_any  = |o_mask;

endmodule

// ===== hdl/hkd_keymap.sv =====
// ----------------------------------------------------------------------------
// hkd_keymap
// 256-entry key-down map: one write and one registered read per cycle,
// every entry cleared by reset.
// ----------------------------------------------------------------------------
module hkd_keymap
    import hkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [CODE_W-1:0] i_rd_addr,
    output logic              o_rd_down
);

    logic [KEY_CODES-1:0] r_down;
    logic                 r_rd_down;

    // map update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down <= '0;
        end else if (i_wr.en) begin
            r_down[i_wr.addr] <= i_wr.down;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_down <= r_down[i_rd_addr];
        end
    end

    assign o_rd_down = r_rd_down;

endmodule

// ===== hdl/hid_report_key_event_diff.sv =====
// ----------------------------------------------------------------------------
// hid_report_key_event_diff
// HID boot keyboard report differ with key-down map. Each report beat is
// compared, slot by slot in parallel lanes, with the stored previous report
// in the cycle it is accepted; the changes (modifiers E0 E4 E1 E5 E2 E6,
// then new keys, then released keys, each in slot order) leave one beat per
// cycle on the output stream while it is not stalled, tlast on the final one.
// A report without changes produces no beat. A query beat (tuser = 1) returns
// the key-down state of query_key in one beat with tuser and tlast set. A
// report holds the event sequencer until all of its events (1 to 18) have
// issued, a query through a map read and then its answer, paced by the single
// output register and the one read port of the key map. The next input beat
// is taken in the cycle the current one issues its last result.
// ----------------------------------------------------------------------------
module hid_report_key_event_diff
    import hkd_pkg::*;
#(
    parameter int KEY_SLOTS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: report_modifiers, key_slot_0 .. key_slot_5, query_key
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: command
    input  logic                 i_s_tuser,
    // output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: event_pressed, event_code, 7 zero bits
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // tuser: answer_kind
    output logic                 o_m_tuser,
    // tlast: last_of_run
    output logic                 o_m_tlast
);

    `include "hid_report_key_event_diff_assert.svh"

    localparam int NEV = MOD_EVENTS + 2 * KEY_SLOTS;

    // input beat fields
    logic [7:0]                      in_mods;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] in_cur;
    logic [CODE_W-1:0]               in_qkey;
    logic                            s_accept;

    // stored previous report
    logic [7:0]                      r_prev_mods;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] r_prev_keys;

    // lanes and merge
    t_lane_res [KEY_SLOTS-1:0]       lane_res;
    logic [NEV-1:0]                  mg_mask;
    logic [MOD_EVENTS-1:0]           mg_mod_down;
    logic                            mg_any;

    // job in the event sequencer
    logic                            r_job_vld;
    logic                            r_job_qry;
    logic                            r_qry_rd;
    logic [NEV-1:0]                  r_job_mask;
    logic [MOD_EVENTS-1:0]           r_job_mods;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] r_job_cur;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] r_job_prev;
    logic [CODE_W-1:0]               r_job_key;

    // event selection
    logic [NEV-1:0][CODE_W-1:0]      ev_code;
    logic [NEV-1:0]                  ev_down;
    logic [NEV-1:0]                  sel;
    logic [NEV-1:0]                  rest;
    logic [CODE_W-1:0]               sel_code;
    logic                            sel_down;
    logic                            out_free;
    logic                            fire;
    logic                            fire_last;
    logic                            qry_emit;
    logic                            job_done;

    // key map port
    t_map_wr                         map_wr;
    logic                            map_rd_en;
    logic                            map_rd_down;

    // output register
    logic                            r_out_vld;
    logic                            r_out_kind;
    logic                            r_out_down;
    logic [CODE_W-1:0]               r_out_code;
    logic                            r_out_last;

    // unpack the input beat; slots past the six inputs read as empty
    assign in_mods = i_s_tdata[7:0];
    assign in_qkey = i_s_tdata[S_TDATA_W-1 -: CODE_W];

    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cur
        if (i < IN_SLOTS) begin : g_in
            assign in_cur[i] = i_s_tdata[CODE_W*(i+1) +: CODE_W];
        end else begin : g_pad
            assign in_cur[i] = '0;
        end
    end

    // one lane per slot
    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
        hkd_lane #(
            .SLOTS (KEY_SLOTS)
        ) u_lane (
            .i_cur_code  (in_cur[i]),
            .i_prev_code (r_prev_keys[i]),
            .i_cur_all   (in_cur),
            .i_prev_all  (r_prev_keys),
            .o_res       (lane_res[i])
        );
    end

    hkd_merge #(
        .SLOTS (KEY_SLOTS)
    ) u_merge (
        .i_mods      (in_mods),
        .i_prev_mods (r_prev_mods),
        .i_lane      (lane_res),
        .o_mask      (mg_mask),
        .o_mod_down  (mg_mod_down),
        .o_any       (mg_any)
    );

    // handshake
    assign out_free   = !r_out_vld || i_m_tready;
    assign fire       = r_job_vld && !r_job_qry && out_free;
    assign fire_last  = fire && (rest == '0);
    assign qry_emit   = r_job_vld && r_job_qry && r_qry_rd && out_free;
    assign job_done   = fire_last || qry_emit;
    assign o_s_tready = !r_job_vld || job_done;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // event table of the current job
    always_comb begin
        for (int k = 0; k < MOD_EVENTS; k++) begin
            ev_code[k] = MOD_CODE[k];
            ev_down[k] = r_job_mods[k];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            ev_code[MOD_EVENTS + i]             = r_job_cur[i];
            ev_down[MOD_EVENTS + i]             = 1'b1;
            ev_code[MOD_EVENTS + KEY_SLOTS + i] = r_job_prev[i];
            ev_down[MOD_EVENTS + KEY_SLOTS + i] = 1'b0;
        end
    end

    // lowest pending event, as a one-hot pick
    assign sel  = r_job_mask & (~r_job_mask + NEV'(1));
    assign rest = r_job_mask & ~sel;

    always_comb begin
        sel_code = '0;
        sel_down = 1'b0;
        for (int k = 0; k < NEV; k++) begin
            if (sel[k]) begin
                sel_code = sel_code | ev_code[k];
                sel_down = sel_down | ev_down[k];
            end
        end
    end

    // stored report, updated as each report beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            r_prev_keys <= '0;
        end else if (s_accept && (i_s_tuser == CMD_REPORT)) begin
            r_prev_mods <= in_mods;
            r_prev_keys <= in_cur;
        end
    end

    // job control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_job_qry <= 1'b0;
            r_qry_rd  <= 1'b0;
        end else if (s_accept) begin
            r_job_vld <= (i_s_tuser == CMD_QUERY) || mg_any;
            r_job_qry <= (i_s_tuser == CMD_QUERY);
            r_qry_rd  <= 1'b0;
        end else begin
            if (job_done) begin
                r_job_vld <= 1'b0;
            end
            if (map_rd_en) begin
                r_qry_rd <= 1'b1;
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_job_mask <= mg_mask;
            r_job_mods <= mg_mod_down;
            r_job_cur  <= in_cur;
            r_job_prev <= r_prev_keys;
            r_job_key  <= in_qkey;
        end else if (fire) begin
            r_job_mask <= rest;
        end
    end

    // key map: written as each event beat issues, read once per query
    assign map_wr.en   = fire;
    assign map_wr.addr = sel_code;
    assign map_wr.down = sel_down;
    assign map_rd_en   = r_job_vld && r_job_qry && !r_qry_rd;

    hkd_keymap u_keymap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (map_wr),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (r_job_key),
        .o_rd_down (map_rd_down)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire || qry_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind <= KIND_EVENT;
            r_out_down <= sel_down;
            r_out_code <= sel_code;
            r_out_last <= (rest == '0);
        end else if (qry_emit) begin
            r_out_kind <= KIND_ANSWER;
            r_out_down <= map_rd_down;
            r_out_code <= r_job_key;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {(M_TDATA_W - CODE_W - 1)'(0), r_out_code, r_out_down};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    // checks
    `HKD_ASSERT_NOW(a_answer_last, o_m_tvalid && (o_m_tuser == KIND_ANSWER), o_m_tlast,
        "query answer without tlast")
    `HKD_ASSERT_NOW(a_report_job_pending, r_job_vld && !r_job_qry, r_job_mask != '0,
        "report job held with no pending event")
    `HKD_ASSERT_NEXT(a_run_continues, fire && (rest != '0), r_job_vld && !r_job_qry,
        "event run cut short before tlast")
    `HKD_ASSERT_NEXT(a_mask_shrinks, r_job_vld && !s_accept,
        (r_job_mask & ~$past(r_job_mask)) == '0, "pending event mask grew mid job")

endmodule

// ===== tb/sv/tb_hid_report_key_event_diff.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hid_report_key_event_diff
// Drives keyboard reports and key-down queries into the report differ and
// checks every output beat against a behavioral copy of the differ kept in
// a scoreboard. A directed opening covers modifier changes, ignored GUI
// bits, duplicate and moved keys, full 18-event reports and queries; random
// keyboard-like sequences, noise reports and queries follow, with random
// gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_hid_report_key_event_diff;
    import hkd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    // longest quiet stretch of a good run is the output hold-off; margin on top
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int DRAIN_CYCLES   = 20;

    typedef logic [CODE_W-1:0]               key_code_t;
    typedef logic [IN_SLOTS-1:0][CODE_W-1:0] slot_vec_t;

    // one beat on the output stream
    typedef struct packed {
        logic      kind;
        logic      pressed;
        key_code_t code;
        logic      last;
    } key_event_t;

    // modifier event order: LCtrl, RCtrl, LShift, RShift, LAlt, RAlt
    localparam int        MOD_ORDER_BIT  [MOD_EVENTS] = '{0, 4, 1, 5, 2, 6};
    localparam key_code_t MOD_ORDER_CODE [MOD_EVENTS] =
        '{8'hE0, 8'hE4, 8'hE1, 8'hE5, 8'hE2, 8'hE6};

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the stored report and key map, queues the events
    // ------------------------------------------------------------------------
    class key_event_scoreboard;
        logic [7:0]  last_mods;
        slot_vec_t   last_slots;
        bit          key_down [KEY_CODES];
        key_event_t  expected_q [$];
        int          errors;

        function new();
            last_mods  = '0;
            last_slots = '0;
            foreach (key_down[k]) key_down[k] = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit slots_hold(slot_vec_t slots, key_code_t code);
            for (int j = 0; j < IN_SLOTS; j++)
                if (slots[j] == code) return 1'b1;
            return 1'b0;
        endfunction

        // key change: update the map and queue the event beat
        function void add_key_event(logic pressed, key_code_t code);
            key_event_t ev;
            key_down[code] = pressed;
            ev = '{kind: KIND_EVENT, pressed: pressed, code: code, last: 1'b0};
            expected_q.push_back(ev);
        endfunction

        // accepted input beat
        function void note_input(logic cmd, logic [S_TDATA_W-1:0] data);
            logic [7:0] mods;
            logic [7:0] changed;
            slot_vec_t  cur;
            key_code_t  qk;
            key_event_t ev;
            int         first;
            first = expected_q.size();
            if (cmd == CMD_QUERY) begin
                qk = data[63:56];
                ev = '{kind: KIND_ANSWER, pressed: key_down[qk], code: qk, last: 1'b1};
                expected_q.push_back(ev);
                return;
            end
            mods    = data[7:0];
            cur     = data[55:8];
            changed = mods ^ last_mods;
            for (int i = 0; i < MOD_EVENTS; i++)
                if (changed[MOD_ORDER_BIT[i]])
                    add_key_event(mods[MOD_ORDER_BIT[i]], MOD_ORDER_CODE[i]);
            // new keys, then vanished keys, each in slot order
            for (int i = 0; i < IN_SLOTS; i++)
                if (cur[i] != '0 && !slots_hold(last_slots, cur[i]))
                    add_key_event(1'b1, cur[i]);
            for (int i = 0; i < IN_SLOTS; i++)
                if (last_slots[i] != '0 && !slots_hold(cur, last_slots[i]))
                    add_key_event(1'b0, last_slots[i]);
            last_mods  = mods;
            last_slots = cur;
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, exp_val, got_val);
                errors++;
            end
        endfunction

        // accepted output beat
        function void check_result(key_event_t got);
            key_event_t exp_ev;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual kind %0h code %0h",
                         $time, got.kind, got.code);
                errors++;
                return;
            end
            exp_ev = expected_q.pop_front();
            compare_field("answer_kind", int'(exp_ev.kind), int'(got.kind));
            compare_field("event_pressed", int'(exp_ev.pressed), int'(got.pressed));
            compare_field("event_code", int'(exp_ev.code), int'(got.code));
            compare_field("last_of_run", int'(exp_ev.last), int'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tlast;

    key_event_scoreboard key_sb = new();

    bit sender_gapless = 1'b0;
    bit hold_request   = 1'b0;
    int idle_cycles    = 0;

    hid_report_key_event_diff u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // small pool most of the time so presses and releases meet
    function automatic key_code_t pick_code();
        if ($urandom_range(0, 4) != 0) return key_code_t'($urandom_range(8'h04, 8'h0B));
        return key_code_t'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic cmd, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = sender_gapless ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_report(input logic [7:0] mods, input slot_vec_t slots,
                               input key_code_t qk);
        send_beat(CMD_REPORT, {qk, slots, mods});
    endtask

    task automatic send_query(input key_code_t qk, input logic [55:0] junk);
        send_beat(CMD_QUERY, {qk, junk});
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, quiet stretches, one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int mode_left;
        bit no_stall;
        stall_left = 0;
        mode_left  = 0;
        no_stall   = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    no_stall  = ($urandom_range(0, 3) == 0);
                    mode_left = $urandom_range(50, 200);
                end
                mode_left--;
                if (stall_left > 0) begin
                    i_m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    i_m_tready <= 1'b1;
                    if (!no_stall && $urandom_range(0, 3) == 0) stall_left = idle_len();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Beat monitor and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                key_sb.check_result('{kind: o_m_tuser, pressed: o_m_tdata[0],
                                      code: o_m_tdata[8:1], last: o_m_tlast});
            if (i_s_tvalid && o_s_tready)
                key_sb.note_input(i_s_tuser, i_s_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] held_mods;
        slot_vec_t  held_slots;
        int         r;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= CMD_REPORT;
        i_s_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: empty map, all modifiers, GUI ignored, no-change report
        send_query(8'h00, '0);
        send_query(8'hFF, '1);
        send_report(8'hFF, {8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h04}, 8'hFF);
        send_query(8'hE0, '0);
        send_query(8'hFF, '0);
        send_query(8'hE3, '0);
        send_report(8'hFF, {8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h04}, 8'h00);
        send_report(8'h88, '0, 8'h00);
        send_report(8'h00, '0, 8'h00);
        // duplicates, key moving slots, single release
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h10, 8'h10, 8'h10}, 8'h00);
        send_report(8'h00, {8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 8'h00);
        send_report(8'h00, '0, 8'h00);
        // twelve events, then the full eighteen, then a reorder
        send_report(8'h77, {8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01}, 8'h00);
        send_report(8'h00, {8'h0C, 8'h0B, 8'h0A, 8'h09, 8'h08, 8'h07}, 8'hA5);
        send_report(8'h00, {8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C}, 8'h00);
        // keycode shared with a modifier code in the map
        send_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0}, 8'h00);
        send_query(8'hE0, '0);
        send_report(8'h01, '0, 8'h00);
        send_query(8'hE0, '0);
        send_report(8'h00, '0, 8'h00);

        held_mods  = 8'h00;
        held_slots = '0;

        // random: mostly evolving key state, some queries and noise reports
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_gapless = (n >= 40 && n < 70);
            if (n == RANDOM_ITEMS / 2) begin
                // output held off while reports keep coming back to back
                hold_request   = 1'b1;
                sender_gapless = 1'b1;
                for (int k = 0; k < 10; k++) begin
                    if (k % 2 == 0) begin
                        held_mods  = 8'h77;
                        held_slots = {8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01};
                    end else begin
                        held_mods  = 8'h00;
                        held_slots = {8'h0C, 8'h0B, 8'h0A, 8'h09, 8'h08, 8'h07};
                    end
                    send_report(held_mods, held_slots, key_code_t'($urandom));
                end
                sender_gapless = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                send_query((r < 12) ? pick_code() : key_code_t'($urandom_range(0, 255)),
                           56'({$urandom, $urandom}));
            end else if (r < 30) begin
                held_mods  = 8'($urandom);
                held_slots = slot_vec_t'({$urandom, $urandom});
                send_report(held_mods, held_slots, key_code_t'($urandom));
            end else begin
                for (int s = 0; s < IN_SLOTS; s++)
                    if ($urandom_range(0, 9) < 3)
                        held_slots[s] = ($urandom_range(0, 1) == 0) ? 8'h00 : pick_code();
                if ($urandom_range(0, 2) == 0) held_mods[$urandom_range(0, 7)] ^= 1'b1;
                send_report(held_mods, held_slots, key_code_t'($urandom));
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (key_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (key_sb.errors == 0 && key_sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hkd_pkg.sv
hdl/hkd_lane.sv
hdl/hkd_merge.sv
hdl/hkd_keymap.sv
hdl/hid_report_key_event_diff.sv
tb/sv/tb_hid_report_key_event_diff.sv
